// ===== rtl/mic_pkg.sv =====
package mic_pkg;

	localparam int FIELD_W    = 20;
	localparam int SCALE_W    = 16;
	localparam int CALIB_W    = 10;
	localparam int WARM_W     = 4;
	localparam int CPU_W      = 10;
	localparam int CNT_W      = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam int AXES       = 3;
	localparam int OUT_W      = ((AXES * FIELD_W + 7) / 8) * 8;
	localparam int FIELD_MAX  = 2 ** (FIELD_W - 1) - 1;
	localparam int FIELD_MAG_MIN = 2 ** (FIELD_W - 1);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CALIB_SAMPLES  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WARMUP_SAMPLES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNTS_PER_UT  = 2'd2;

	localparam logic [1:0] AXIS_FIRST = 2'd0;
	localparam logic [1:0] AXIS_LAST  = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL,
		ST_RANGE,
		ST_DSTART,
		ST_DWAIT,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		MODE_MEAS,
		MODE_SCALE,
		MODE_OFFS
	} mode_t;

	typedef struct packed {
		logic       load;
		logic       begin_cal;
		logic       track;
		logic       mul;
		logic       range;
		logic       div_start;
		logic       store;
		logic       emit;
		mode_t      mode;
		logic [1:0] axis;
	} cmd_t;

	typedef struct packed {
		logic op;
		logic calibrating;
		logic run_end;
		logic div_done;
	} status_t;

endpackage

// ===== rtl/magnetometer_iron_calibration.sv =====
// measure beat: the shared one-bit-per-cycle divider runs once per axis; a calibration
// sample is loaded and then tracked before the next one is taken
// run end: a range step, then three scale and three offset divisions
// one beat in flight at a time; the next beat is taken while a result waits in the output reg
// arst_n clears registers to their defaults, scale to one, offsets to zero, min/max trackers
// to the extreme values; no clearing pass is needed
module magnetometer_iron_calibration import mic_pkg::*; #(
	parameter int SAMPLE_WIDTH    = 16,
	parameter int SCALE_FRAC_BITS = 12
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// sample stream in
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	input  logic [((3*SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,  // raw_x, raw_y, raw_z, zero pad
	input  logic                                    s_tuser,  // operation
	// result stream out
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	output logic [OUT_W-1:0]                        m_tdata,  // field_x, field_y, field_z, zero pad
	output logic                                    m_tuser,  // kind
	// register write channel
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]                    cfg_index,
	input  logic [CFG_DATA_W-1:0]                   cfg_data
);

	status_t                    status;
	cmd_t                       cmd;
	logic [AXES*FIELD_W-1:0]    out_data;

	// register writes are always accepted
	assign cfg_ready = 1'b1;

	// sequencer: accept, evaluate, calibration tracking and range, per-axis multiply and divide, emit
	mic_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.status  (status),
		.cmd     (cmd)
	);

	// trackers, calibration state, multiplier, divider and output register
	mic_datapath #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.SCALE_FRAC_BITS(SCALE_FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_op    (s_tuser),
		.in_raw   (s_tdata[3*SAMPLE_WIDTH-1:0]),
		.cmd      (cmd),
		.status   (status),
		.out_kind (m_tuser),
		.out_data (out_data)
	);

	// pad the three fields up to whole bytes
	assign m_tdata = OUT_W'(out_data);

endmodule

// ===== rtl/mic_div.sv =====
module mic_div #(
	parameter int NW = 41,
	parameter int DW = 27
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int CW = $clog2(NW + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quo_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          fits;

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, quo_q[NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== rtl/mic_datapath.sv =====
module mic_datapath import mic_pkg::*; #(
	parameter int SAMPLE_WIDTH    = 16,
	parameter int SCALE_FRAC_BITS = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_data,
	input  logic                        in_op,
	input  logic [AXES*SAMPLE_WIDTH-1:0] in_raw,
	input  cmd_t                        cmd,
	output status_t                     status,
	output logic                        out_kind,
	output logic [AXES*FIELD_W-1:0]     out_data
);

	localparam int SW = SAMPLE_WIDTH;
	localparam int F  = SCALE_FRAC_BITS;
	localparam int NW = SW + 25;
	localparam int DW = (F + 11 > SW + 2) ? F + 11 : SW + 2;
	localparam int PW = SW + 1 + SCALE_W;
	localparam logic [SW-1:0] MIN_INIT = {1'b0, {(SW-1){1'b1}}};
	localparam logic [SW-1:0] MAX_INIT = {1'b1, {(SW-1){1'b0}}};
	localparam logic [SCALE_W-1:0] SCALE_ONE = (F >= SCALE_W) ? '1 : SCALE_W'(1 << F);

	logic [CALIB_W-1:0] calib_q;
	logic [WARM_W-1:0]  warm_q;
	logic [CPU_W-1:0]   cpu_q;

	logic               op_q;
	logic [SW-1:0]      raw_q [AXES];
	logic [SW-1:0]      min_q [AXES];
	logic [SW-1:0]      max_q [AXES];
	logic [SW:0]        off_q [AXES];
	logic [SCALE_W-1:0] scl_q [AXES];
	logic [SW-1:0]      rng_q [AXES];
	logic [SW+1:0]      sum_q;
	logic               cal_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [PW-1:0]      prod_q;
	logic               neg_q;
	logic [FIELD_W-1:0] res_q [AXES];
	logic [FIELD_W-1:0] out_q [AXES];
	logic               out_kind_q;

	logic [CPU_W-1:0]   cpu_eff;
	logic [CALIB_W-1:0] calib_eff;
	logic [CNT_W-1:0]   target;
	logic [CNT_W-1:0]   cnt_next;
	logic               run_end;
	logic               tracked;
	logic [SW-1:0]      rng_w [AXES];
	logic [SW:0]        offs_w [AXES];
	logic [SW+1:0]      sum_w;
	logic [SW+1:0]      d;
	logic [SW+1:0]      d_abs;
	logic [SW:0]        off_abs;
	logic [PW-1:0]      prod_w;
	logic [SW+1:0]      den3;
	logic [NW-1:0]      div_num;
	logic [DW-1:0]      div_den;
	logic               div_done;
	logic [NW-1:0]      quo;
	logic               res_neg;
	logic [FIELD_W-1:0] field_val;
	logic [SCALE_W-1:0] scale_val;

	assign cpu_eff   = (cpu_q == '0) ? CPU_W'(1) : cpu_q;
	assign calib_eff = (calib_q == '0) ? CALIB_W'(1) : calib_q;
	assign target    = CNT_W'(warm_q) + CNT_W'(calib_eff);
	assign cnt_next  = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;
	assign run_end   = cnt_next >= target;
	assign tracked   = cnt_next > CNT_W'(warm_q);

	always_comb begin
		logic [SW:0] diff;
		sum_w = '0;
		for (int i = 0; i < AXES; i++) begin
			diff      = {max_q[i][SW-1], max_q[i]} - {min_q[i][SW-1], min_q[i]};
			rng_w[i]  = (!diff[SW] && diff != '0) ? diff[SW-1:0] : '0;
			offs_w[i] = {max_q[i][SW-1], max_q[i]} + {min_q[i][SW-1], min_q[i]};
			sum_w     = sum_w + (SW+2)'(rng_w[i]);
		end
	end

	// doubled raw minus offset, both in half-counts
	assign d       = {raw_q[cmd.axis][SW-1], raw_q[cmd.axis], 1'b0}
	               - {off_q[cmd.axis][SW], off_q[cmd.axis]};
	assign d_abs   = d[SW+1] ? (~d + 1'b1) : d;
	assign off_abs = off_q[cmd.axis][SW] ? (~off_q[cmd.axis] + 1'b1) : off_q[cmd.axis];
	assign prod_w  = {{SCALE_W{1'b0}}, d_abs[SW:0]} * {{(SW+1){1'b0}}, scl_q[cmd.axis]};
	assign den3    = {2'b00, rng_q[cmd.axis]} + {1'b0, rng_q[cmd.axis], 1'b0};

	// magnitude plus half the divisor, so the floor quotient rounds half away
	always_comb begin
		unique case (cmd.mode)
			MODE_MEAS: begin
				div_num = (NW'(prod_q) << 6) + (NW'(cpu_eff) << F);
				div_den = DW'(cpu_eff) << (F + 1);
			end
			MODE_SCALE: begin
				div_num = (NW'(sum_q) << F) + NW'(den3 >> 1);
				div_den = DW'(den3);
			end
			MODE_OFFS: begin
				div_num = (NW'(off_abs) << 6) + NW'(cpu_eff);
				div_den = DW'({cpu_eff, 1'b0});
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	mic_div #(
		.NW(NW),
		.DW(DW)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (div_den),
		.done  (div_done),
		.quo   (quo)
	);

	assign res_neg = (cmd.mode == MODE_MEAS) ? neg_q : off_q[cmd.axis][SW];

	always_comb begin
		if (!res_neg) begin
			field_val = (quo > NW'(FIELD_MAX)) ? FIELD_W'(FIELD_MAX) : quo[FIELD_W-1:0];
		end else if (quo > NW'(FIELD_MAG_MIN)) begin
			field_val = {1'b1, {(FIELD_W-1){1'b0}}};
		end else begin
			field_val = ~quo[FIELD_W-1:0] + 1'b1;
		end
		if (rng_q[cmd.axis] == '0 || quo > NW'({SCALE_W{1'b1}})) begin
			scale_val = '1;
		end else begin
			scale_val = quo[SCALE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_q <= CALIB_W'(100);
			warm_q  <= WARM_W'(3);
			cpu_q   <= CPU_W'(120);
			cal_q   <= 1'b0;
			cnt_q   <= '0;
			for (int i = 0; i < AXES; i++) begin
				min_q[i] <= MIN_INIT;
				max_q[i] <= MAX_INIT;
				off_q[i] <= '0;
				scl_q[i] <= SCALE_ONE;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_CALIB_SAMPLES:  calib_q <= cfg_data[CALIB_W-1:0];
					REG_WARMUP_SAMPLES: warm_q  <= cfg_data[WARM_W-1:0];
					REG_COUNTS_PER_UT:  cpu_q   <= cfg_data[CPU_W-1:0];
					default: ;
				endcase
			end
			if (cmd.begin_cal) begin
				cal_q <= 1'b1;
				cnt_q <= '0;
				for (int i = 0; i < AXES; i++) begin
					min_q[i] <= MIN_INIT;
					max_q[i] <= MAX_INIT;
				end
			end
			if (cmd.track) begin
				cnt_q <= cnt_next;
				if (run_end) begin
					cal_q <= 1'b0;
				end
				if (tracked) begin
					for (int i = 0; i < AXES; i++) begin
						if ($signed(raw_q[i]) < $signed(min_q[i])) min_q[i] <= raw_q[i];
						if ($signed(raw_q[i]) > $signed(max_q[i])) max_q[i] <= raw_q[i];
					end
				end
			end
			if (cmd.range) begin
				for (int i = 0; i < AXES; i++) begin
					off_q[i] <= offs_w[i];
				end
			end
			if (cmd.store && cmd.mode == MODE_SCALE) begin
				scl_q[cmd.axis] <= scale_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_op;
			for (int i = 0; i < AXES; i++) begin
				raw_q[i] <= in_raw[i*SW +: SW];
			end
		end
		if (cmd.range) begin
			sum_q <= sum_w;
			for (int i = 0; i < AXES; i++) begin
				rng_q[i] <= rng_w[i];
			end
		end
		if (cmd.mul) begin
			prod_q <= prod_w;
			neg_q  <= d[SW+1];
		end
		if (cmd.store && cmd.mode != MODE_SCALE) begin
			res_q[cmd.axis] <= field_val;
		end
		if (cmd.emit) begin
			out_kind_q <= (cmd.mode == MODE_OFFS);
			for (int i = 0; i < AXES; i++) begin
				out_q[i] <= res_q[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < AXES; i++) begin
			out_data[i*FIELD_W +: FIELD_W] = out_q[i];
		end
	end

	assign out_kind           = out_kind_q;
	assign status.op          = op_q;
	assign status.calibrating = cal_q;
	assign status.run_end     = run_end;
	assign status.div_done    = div_done;

endmodule

// ===== rtl/mic_ctrl.sv =====
module mic_ctrl import mic_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	input  logic    m_tready,
	output logic    m_tvalid,
	input  status_t status,
	output cmd_t    cmd
);

	state_t     state_q, state_d;
	mode_t      mode_q, mode_d;
	logic [1:0] axis_q, axis_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		mode_d  = mode_q;
		axis_d  = axis_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (status.op) begin
					state_d = ST_IDLE;
				end else if (status.calibrating) begin
					state_d = status.run_end ? ST_RANGE : ST_IDLE;
				end else begin
					state_d = ST_MUL;
					mode_d  = MODE_MEAS;
					axis_d  = AXIS_FIRST;
				end
			end
			ST_RANGE: begin
				state_d = ST_DSTART;
				mode_d  = MODE_SCALE;
				axis_d  = AXIS_FIRST;
			end
			ST_MUL:    state_d = ST_DSTART;
			ST_DSTART: state_d = ST_DWAIT;
			ST_DWAIT: begin
				if (status.div_done) begin
					if (axis_q == AXIS_LAST) begin
						if (mode_q == MODE_SCALE) begin
							state_d = ST_DSTART;
							mode_d  = MODE_OFFS;
							axis_d  = AXIS_FIRST;
						end else begin
							state_d = ST_EMIT;
						end
					end else begin
						axis_d  = axis_q + 1'b1;
						state_d = (mode_q == MODE_MEAS) ? ST_MUL : ST_DSTART;
					end
				end
			end
			ST_EMIT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.mode = mode_q;
		cmd.axis = axis_q;
		unique case (state_q)
			ST_IDLE:   cmd.load      = s_tvalid;
			ST_EVAL: begin
				cmd.begin_cal = status.op;
				cmd.track     = !status.op && status.calibrating;
			end
			ST_MUL:    cmd.mul       = 1'b1;
			ST_RANGE:  cmd.range     = 1'b1;
			ST_DSTART: cmd.div_start = 1'b1;
			ST_DWAIT:  cmd.store     = status.div_done;
			ST_EMIT:   cmd.emit      = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_MEAS;
			axis_q      <= AXIS_FIRST;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			axis_q  <= axis_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

endmodule
